[rtl/core/mcut_pkg.sv]
// Shared types and constants for the dense global minimum cut engine.
package mcut_pkg;

    localparam int unsigned FUNC_BITS = 2;
    localparam int unsigned NODE_BITS = 6;
    localparam int unsigned EDGE_BITS = 16;
    localparam int unsigned CUT_BITS  = 32;
    localparam int unsigned CFG_BITS  = 7;

    localparam logic [CUT_BITS-1:0] ALL_ONES = '1;
    localparam logic [CFG_BITS-1:0] NODE_COUNT_RESET = 7'd64;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_RUN   = 2'd2
    } t_func;

    typedef struct packed {
        logic [CUT_BITS-1:0] sum;
        logic                gt;
    } t_alu_res;

endpackage

[rtl/core/mcut_if.sv]
// Transaction channels of the minimum cut engine: input items and results.
interface mcut_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [5:0] node_a;
    logic [5:0] node_b;
    logic [15:0] edge_weight;

    modport source (output valid, func, node_a, node_b, edge_weight, input ready);
    modport sink (input valid, func, node_a, node_b, edge_weight, output ready);
endinterface

interface mcut_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] cut_value;

    modport source (output valid, cut_value, input ready);
    modport sink (input valid, cut_value, output ready);
endinterface

[rtl/core/global_min_cut_dense.sv]
// Top level: dense-matrix global minimum cut engine with shared arithmetic unit.
//
//  channel   dir  handshake        payload
//  i_in      in   valid / ready    func, node_a, node_b, edge_weight
//  o_out     out  valid / ready    cut_value
//  cfg       in   i_cfg_we         i_cfg_wdata (node_count)
//
// Write stores both directions of the edge, the second one in S_WR2; clear steps through every matrix entry.
// Run: copies the weight matrix into the work matrix, then per phase initialises the phase
// weights, alternates scan and update passes over all MAX_NODES slots, and merges the last vertex.
// Reset starts a clearing pass over every matrix entry; no item is taken meanwhile.
// A finished result waits in the output register; input is taken while it waits.
module global_min_cut_dense #(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_wdata,
    mcut_in_if.sink            i_in,
    mcut_out_if.source         o_out
);
    import mcut_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int AW    = 2 * NW;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam logic [NW-1:0] LAST_J = NW'(MAX_NODES - 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_WR2, S_CLR, S_COPY, S_COPY_END, S_PH_INIT, S_SCAN,
        S_SCAN_END, S_DECIDE, S_UPD, S_UPD_END, S_MRG_RD, S_MRG_W1, S_MRG_W2, S_DONE
    } t_state;

    t_state r_state;

    logic [WEIGHT_BITS-1:0] r_wmat [0:DEPTH-1];
    logic [31:0]            r_work [0:DEPTH-1];
    logic [31:0]            r_pw   [0:(1<<NW)-1];

    logic [6:0]             r_node_count;
    logic [AW-1:0]          r_sw;
    logic [WEIGHT_BITS-1:0] r_wm_rd;
    logic                   r_cp_vld;
    logic [AW-1:0]          r_cp_addr;
    logic [NW-1:0]          r_a;
    logic [NW-1:0]          r_b;
    logic [WEIGHT_BITS-1:0] r_w;
    logic [NW-1:0]          r_j;
    logic [NW-1:0]          r_jd;
    logic                   r_sv;
    logic                   r_uv;
    logic [31:0]            r_pw_rd;
    logic [31:0]            r_wa_rd;
    logic [31:0]            r_wb_rd;
    logic [MAX_NODES-1:0]   r_active;
    logic [MAX_NODES-1:0]   r_in_set;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_i;
    logic [NW-1:0]          r_last;
    logic [NW-1:0]          r_prev;
    logic                   r_found;
    logic [31:0]            r_best;
    logic [31:0]            r_best_cut;
    logic [31:0]            r_sum;
    logic                   r_out_valid;
    logic [31:0]            r_out_data;

    logic                   wm_we;
    logic [AW-1:0]          wm_addr;
    logic [WEIGHT_BITS-1:0] wm_wdata;
    logic                   wk_we;
    logic [AW-1:0]          wk_addr;
    logic [31:0]            wk_wdata;
    logic                   pw_we;
    logic [NW-1:0]          pw_addr;
    logic [31:0]            pw_wdata;
    logic [31:0]            alu_a;
    logic [31:0]            alu_b;
    t_alu_res               alu;
    logic                   in_acc;
    logic                   in_range;
    logic                   mcond;
    logic [31:0]            n_clamp;
    logic [CW-1:0]          n_nodes;

    mcut_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu)
    );

    assign i_in.ready      = (r_state == S_IDLE);
    assign in_acc          = i_in.valid && i_in.ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.cut_value = r_out_data;
    assign in_range = (32'(i_in.node_a) < MAX_NODES) && (32'(i_in.node_b) < MAX_NODES);
    assign mcond    = r_active[r_j] && (r_j != r_last) && (r_j != r_prev);
    assign n_clamp  = (32'(r_node_count) > MAX_NODES) ? 32'(MAX_NODES) : 32'(r_node_count);
    assign n_nodes  = CW'(n_clamp);

    always_comb begin
        if (r_uv) begin
            alu_a = r_pw_rd;
            alu_b = r_wa_rd;
        end else begin
            unique case (r_state)
                S_MRG_W1: begin
                    alu_a = r_wa_rd;
                    alu_b = r_wb_rd;
                end
                S_DECIDE: begin
                    alu_a = r_best_cut;
                    alu_b = r_best;
                end
                default: begin
                    alu_a = r_pw_rd;
                    alu_b = r_best;
                end
            endcase
        end
    end

    always_comb begin
        wm_we    = 1'b0;
        wm_addr  = r_sw;
        wm_wdata = '0;
        if (r_state == S_INIT || r_state == S_CLR) begin
            wm_we = 1'b1;
        end else if (r_state == S_WR2) begin
            wm_we    = 1'b1;
            wm_addr  = {r_b, r_a};
            wm_wdata = r_w;
        end else if (in_acc && i_in.func == FUNC_WRITE && in_range) begin
            wm_we    = 1'b1;
            wm_addr  = {NW'(i_in.node_a), NW'(i_in.node_b)};
            wm_wdata = WEIGHT_BITS'(i_in.edge_weight);
        end
    end

    always_comb begin
        wk_we    = 1'b0;
        wk_addr  = r_cp_addr;
        wk_wdata = 32'(r_wm_rd);
        if (r_cp_vld) begin
            wk_we = 1'b1;
        end else if (r_state == S_MRG_W1 && mcond) begin
            wk_we    = 1'b1;
            wk_addr  = {r_prev, r_j};
            wk_wdata = alu.sum;
        end else if (r_state == S_MRG_W2 && mcond) begin
            wk_we    = 1'b1;
            wk_addr  = {r_j, r_prev};
            wk_wdata = r_sum;
        end
    end

    always_comb begin
        pw_we    = 1'b0;
        pw_addr  = r_j;
        pw_wdata = '0;
        if (r_state == S_PH_INIT) begin
            pw_we = 1'b1;
        end else if (r_uv && r_active[r_jd] && !r_in_set[r_jd]) begin
            pw_we    = 1'b1;
            pw_addr  = r_jd;
            pw_wdata = alu.sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wm_we) begin
            r_wmat[wm_addr] <= wm_wdata;
        end
        r_wm_rd <= r_wmat[r_sw];
    end

    always_ff @(posedge i_clk) begin
        if (wk_we) begin
            r_work[wk_addr] <= wk_wdata;
        end
        r_wa_rd <= r_work[{r_last, r_j}];
        r_wb_rd <= r_work[{r_prev, r_j}];
    end

    always_ff @(posedge i_clk) begin
        if (pw_we) begin
            r_pw[pw_addr] <= pw_wdata;
        end
        r_pw_rd <= r_pw[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_node_count <= NODE_COUNT_RESET;
            r_sw         <= '0;
            r_cp_vld     <= 1'b0;
            r_sv         <= 1'b0;
            r_uv         <= 1'b0;
            r_j          <= '0;
            r_active     <= '1;
            r_in_set     <= '0;
            r_count      <= '0;
            r_i          <= '0;
            r_last       <= '0;
            r_prev       <= '0;
            r_found      <= 1'b0;
            r_best_cut   <= ALL_ONES;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            r_sv      <= (r_state == S_SCAN);
            r_uv      <= (r_state == S_UPD);
            r_jd      <= r_j;
            r_cp_vld  <= (r_state == S_COPY);
            r_cp_addr <= r_sw;
            if (r_state == S_DONE && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_sv && r_active[r_jd] && !r_in_set[r_jd] && (!r_found || alu.gt)) begin
                r_best  <= r_pw_rd;
                r_last  <= r_jd;
                r_found <= 1'b1;
            end
            unique case (r_state)
                S_INIT, S_CLR: begin
                    r_sw <= r_sw + 1'b1;
                    if (r_sw == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_in.func)
                            FUNC_WRITE: begin
                                if (in_range) begin
                                    r_a     <= NW'(i_in.node_a);
                                    r_b     <= NW'(i_in.node_b);
                                    r_w     <= WEIGHT_BITS'(i_in.edge_weight);
                                    r_state <= S_WR2;
                                end
                            end
                            FUNC_CLEAR: begin
                                r_sw    <= '0;
                                r_state <= S_CLR;
                            end
                            FUNC_RUN: begin
                                r_sw    <= '0;
                                r_state <= S_COPY;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_WR2: begin
                    r_state <= S_IDLE;
                end
                S_COPY: begin
                    r_sw <= r_sw + 1'b1;
                    if (r_sw == '1) begin
                        r_state <= S_COPY_END;
                    end
                end
                S_COPY_END: begin
                    for (int k = 0; k < MAX_NODES; k++) begin
                        r_active[k] <= (32'(k) < n_clamp);
                    end
                    r_in_set   <= '0;
                    r_best_cut <= ALL_ONES;
                    r_count    <= n_nodes;
                    r_j        <= '0;
                    r_state    <= (n_clamp < 32'd2) ? S_DONE : S_PH_INIT;
                end
                S_PH_INIT: begin
                    r_in_set <= '0;
                    r_i      <= '0;
                    if (r_j == LAST_J) begin
                        r_j     <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (r_j == LAST_J) begin
                        r_j     <= '0;
                        r_state <= S_SCAN_END;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_SCAN_END: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_j <= '0;
                    if (r_i == CW'(r_count - 1'b1)) begin
                        if (alu.gt) begin
                            r_best_cut <= r_best;
                        end
                        r_state <= S_MRG_RD;
                    end else begin
                        r_in_set[r_last] <= 1'b1;
                        r_prev           <= r_last;
                        r_i              <= r_i + 1'b1;
                        r_state          <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (r_j == LAST_J) begin
                        r_j     <= '0;
                        r_state <= S_UPD_END;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_UPD_END: begin
                    r_found <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_MRG_RD: begin
                    r_state <= S_MRG_W1;
                end
                S_MRG_W1: begin
                    r_sum   <= alu.sum;
                    r_state <= S_MRG_W2;
                end
                S_MRG_W2: begin
                    if (r_j == LAST_J) begin
                        r_active[r_last] <= 1'b0;
                        r_count          <= r_count - 1'b1;
                        r_j              <= '0;
                        r_state          <= (r_count == CW'(2)) ? S_DONE : S_PH_INIT;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_MRG_RD;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_data  <= r_best_cut;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_set_within_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_set & ~r_active) == '0)
        else $error("phase set holds an inactive vertex");

    a_merge_last_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MRG_W1) |-> (r_i == CW'(r_count - 1'b1)))
        else $error("merge outside the last phase iteration");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.func == FUNC_RUN) |=> !i_in.ready)
        else $error("ready after accepting a run transaction");

    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_count >= CW'(2)))
        else $error("phase scan with fewer than two vertices");

endmodule

[rtl/core/mcut_alu.sv]
// Shared saturating adder and magnitude comparator.
module mcut_alu (
    input  logic [31:0]        i_a,
    input  logic [31:0]        i_b,
    output mcut_pkg::t_alu_res o_res
);
    import mcut_pkg::*;

    logic [CUT_BITS:0] sum_wide;

    assign sum_wide = {1'b0, i_a} + {1'b0, i_b};

    always_comb begin
        o_res.sum = sum_wide[CUT_BITS] ? ALL_ONES : sum_wide[CUT_BITS-1:0];
        o_res.gt  = (i_a > i_b);
    end
endmodule

[test/mcut_checker.sv]
// Min cut checker: watches the channels, predicts results and compares them.
`timescale 1ns / 1ps
module mcut_checker
    import mcut_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_wdata,
    mcut_in_if                  in_ch,
    mcut_out_if                 out_ch,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_results
);
    localparam int NODES = 64;

    logic [CUT_BITS-1:0] edge_store [NODES][NODES];
    logic [CUT_BITS-1:0] scratch [NODES][NODES];
    logic [CUT_BITS-1:0] adjacency [NODES];
    logic                grown [NODES];
    logic                alive [NODES];
    logic [CFG_BITS-1:0] vertex_total;
    logic [CUT_BITS-1:0] cut_queue [$];

    function automatic logic [CUT_BITS-1:0] sat_sum(logic [CUT_BITS-1:0] x,
                                                    logic [CUT_BITS-1:0] y);
        logic [CUT_BITS:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[CUT_BITS] ? ALL_ONES : s[CUT_BITS-1:0];
    endfunction

    function automatic logic [CUT_BITS-1:0] phase_cut(int count);
        int prev, last;
        bit found;
        logic [CUT_BITS-1:0] cut;
        prev = 0;
        last = 0;
        for (int j = 0; j < NODES; j++) begin
            adjacency[j] = '0;
            grown[j] = 1'b0;
        end
        for (int i = 0; i < count; i++) begin
            found = 0;
            prev = last;
            for (int j = 0; j < NODES; j++) begin
                if (alive[j] && !grown[j] && (!found || adjacency[j] > adjacency[last])) begin
                    last = j;
                    found = 1;
                end
            end
            if (i + 1 == count) begin
                cut = adjacency[last];
                for (int j = 0; j < NODES; j++) begin
                    if (alive[j] && j != last) begin
                        scratch[prev][j] = sat_sum(scratch[prev][j], scratch[last][j]);
                        scratch[j][prev] = sat_sum(scratch[j][prev], scratch[j][last]);
                    end
                end
                alive[last] = 1'b0;
                return cut;
            end
            grown[last] = 1'b1;
            for (int j = 0; j < NODES; j++) begin
                if (alive[j] && !grown[j]) begin
                    adjacency[j] = sat_sum(adjacency[j], scratch[last][j]);
                end
            end
        end
        return ALL_ONES;
    endfunction

    function automatic logic [CUT_BITS-1:0] global_cut();
        int n;
        logic [CUT_BITS-1:0] best, c;
        n = (vertex_total > NODES) ? NODES : int'(vertex_total);
        scratch = edge_store;
        for (int j = 0; j < NODES; j++) begin
            alive[j] = (j < n);
        end
        best = ALL_ONES;
        for (int count = n; count > 1; count--) begin
            c = phase_cut(count);
            if (c < best) begin
                best = c;
            end
        end
        return best;
    endfunction

    assign o_pending = cut_queue.size();

    always @(posedge i_clk) begin
        logic [CUT_BITS-1:0] want;
        if (!i_rst_n) begin
            o_errors = 0;
            o_results = 0;
            vertex_total = NODE_COUNT_RESET;
            cut_queue.delete();
            for (int a = 0; a < NODES; a++) begin
                for (int b = 0; b < NODES; b++) begin
                    edge_store[a][b] = '0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                vertex_total = i_cfg_wdata;
            end
            if (in_ch.valid && in_ch.ready) begin
                case (in_ch.func)
                    FUNC_WRITE: begin
                        edge_store[in_ch.node_a][in_ch.node_b] = {16'd0, in_ch.edge_weight};
                        edge_store[in_ch.node_b][in_ch.node_a] = {16'd0, in_ch.edge_weight};
                    end
                    FUNC_CLEAR: begin
                        for (int a = 0; a < NODES; a++) begin
                            for (int b = 0; b < NODES; b++) begin
                                edge_store[a][b] = '0;
                            end
                        end
                    end
                    FUNC_RUN: cut_queue.push_back(global_cut());
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                o_results++;
                if (cut_queue.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("unexpected result cut_value=%0d", out_ch.cut_value);
                    end
                end else begin
                    want = cut_queue.pop_front();
                    if (out_ch.cut_value !== want) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("cut_value mismatch: expected %0d, got %0d",
                                     want, out_ch.cut_value);
                        end
                    end
                end
            end
        end
    end
endmodule

[test/tb_global_min_cut_dense.sv]
// Testbench top: drives items and configuration into the min cut engine.
`timescale 1ns / 1ps
module tb_global_min_cut_dense;
    import mcut_pkg::*;

    localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 4400;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_BITS-1:0] i_cfg_wdata;
    int                  errors, pending, results, items_sent;
    bit                  no_idle;

    mcut_in_if  in_ch ();
    mcut_out_if out_ch ();

    global_min_cut_dense u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    mcut_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    initial begin
        #(12.0 * 6_000_000);
        $display("tb: failure");
        $finish;
    end

    // receiver: drop ready for a random gap before each transaction, unless no_idle is set
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 18);
            @(negedge i_clk);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    task automatic send_item(logic [FUNC_BITS-1:0] func, logic [NODE_BITS-1:0] a,
                             logic [NODE_BITS-1:0] b, logic [EDGE_BITS-1:0] w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.func        <= func;
        in_ch.node_a      <= a;
        in_ch.node_b      <= b;
        in_ch.edge_weight <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic set_node_count(logic [CFG_BITS-1:0] value);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(int n);
        int r;
        for (int k = 0; k < 16; k++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(FUNC_WRITE, NODE_BITS'($urandom_range(0, 63)),
                              NODE_BITS'($urandom_range(0, 63)), EDGE_BITS'($urandom()));
                end else begin
                    send_item(FUNC_WRITE, NODE_BITS'($urandom_range(0, n)),
                              NODE_BITS'($urandom_range(0, n - 1)), EDGE_BITS'($urandom()));
                end
            end else if (r < 62) begin
                send_item(FUNC_UNUSED, NODE_BITS'($urandom()), NODE_BITS'($urandom()),
                          EDGE_BITS'($urandom()));
            end else if (r < 65) begin
                send_item(FUNC_CLEAR, NODE_BITS'($urandom()), NODE_BITS'($urandom()),
                          EDGE_BITS'($urandom()));
            end else begin
                send_item(FUNC_RUN, NODE_BITS'($urandom()), NODE_BITS'($urandom()),
                          EDGE_BITS'($urandom()));
            end
        end
        send_item(FUNC_RUN, '0, '0, '0);
    endtask

    initial begin
        int n;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_ch.valid       = 1'b0;
        in_ch.func        = FUNC_WRITE;
        in_ch.node_a      = '0;
        in_ch.node_b      = '0;
        in_ch.edge_weight = '0;
        items_sent        = 0;
        no_idle           = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_node_count(7'd4);
        send_item(FUNC_WRITE, 6'd0, 6'd1, 16'hFFFF);
        send_item(FUNC_WRITE, 6'd1, 6'd2, 16'd0);
        send_item(FUNC_WRITE, 6'd2, 6'd2, 16'd500);
        send_item(FUNC_WRITE, 6'd63, 6'd0, 16'd7);
        send_item(FUNC_WRITE, 6'd3, 6'd0, 16'd1);
        send_item(FUNC_WRITE, 6'd2, 6'd3, 16'h5555);
        send_item(FUNC_RUN, 6'd0, 6'd0, 16'd0);
        send_item(FUNC_UNUSED, 6'd63, 6'd63, 16'hFFFF);
        send_item(FUNC_WRITE, 6'd1, 6'd0, 16'hAAAA);
        send_item(FUNC_RUN, 6'd63, 6'd63, 16'hFFFF);
        send_item(FUNC_CLEAR, 6'd0, 6'd0, 16'd0);
        send_item(FUNC_RUN, 6'd0, 6'd0, 16'd0);
        set_node_count(7'd0);
        send_item(FUNC_WRITE, 6'd0, 6'd1, 16'd3);
        send_item(FUNC_RUN, 6'd0, 6'd0, 16'd0);
        set_node_count(7'd1);
        send_item(FUNC_RUN, 6'd0, 6'd0, 16'd0);
        set_node_count(7'd2);
        send_item(FUNC_RUN, 6'd0, 6'd0, 16'd0);

        for (int p = 0; p < 5; p++) begin
            n = $urandom_range(2, 8);
            set_node_count(CFG_BITS'(n));
            no_idle = (p == 2);
            random_phase(n);
        end
        no_idle = 0;

        set_node_count(7'd127);
        send_item(FUNC_WRITE, 6'd63, 6'd62, 16'd9);
        send_item(FUNC_WRITE, 6'd10, 6'd40, 16'd1234);
        send_item(FUNC_RUN, 6'd0, 6'd0, 16'd0);

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("run covered %0d input transactions and %0d checked cut results",
                 items_sent, results);
        $display("node counts 0, 1, 2, 4, random 2..8 and 127 were applied");
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/core/mcut_pkg.sv
rtl/core/mcut_if.sv
rtl/core/mcut_alu.sv
rtl/core/global_min_cut_dense.sv
test/mcut_checker.sv
test/tb_global_min_cut_dense.sv
